[rtl/srd_pkg.sv]
package srd_pkg;

   localparam int SLOTS_DEFAULT = 48;
   localparam int SLOT_OUT_W    = 6;
   localparam int CSR_AW        = 4;
   localparam int CSR_DW        = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_TEMP_THR  = 2'd0;
   localparam logic [1:0] REG_HUM_THR   = 2'd1;
   localparam logic [1:0] REG_BATT_THR  = 2'd2;
   localparam logic [1:0] REG_INTERVAL  = 2'd3;

   localparam logic [13:0] TEMP_THR_RESET = 14'd10;
   localparam logic [6:0]  HUM_THR_RESET  = 7'd1;
   localparam logic [6:0]  BATT_THR_RESET = 7'd1;
   localparam logic [31:0] INTERVAL_RESET = 32'd30000;

   localparam logic CMD_REPORT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic               cmd;
      logic [47:0]        device_addr;
      logic [1:0]         addr_kind;
      logic signed [15:0] temperature;
      logic [6:0]         humidity;
      logic signed [7:0]  battery;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic                  publish;
      logic [SLOT_OUT_W-1:0] slot_used;
      logic                  hit;
      logic [1:0]            stored_kind;
   } rsp_type;

   typedef struct packed {
      logic [47:0] addr;
      logic [1:0]  kind;
      logic [31:0] time_ms;
      logic [15:0] temp;
      logic [6:0]  hum;
      logic [7:0]  batt;
   } entry_type;

   typedef struct packed {
      logic [13:0] temp_thr;
      logic [6:0]  hum_thr;
      logic [6:0]  batt_thr;
      logic [31:0] interval;
   } cfg_type;

endpackage

[rtl/sensor_report_dedup_table.sv]
// Sensor report de-duplication table. A request is taken when start is high and busy is
// low; busy then stays high through the SCAN, DRAIN, DECIDE and FINISH states. The table
// lives in a single-port-read memory, and the address lookup walks it one entry per cycle
// through one shared 48-bit compare, so the table depth sets the latency. rsp_valid is high
// for exactly one cycle with the result, in the first cycle in which busy is low again; the
// receiver cannot stall it, and a new request may be started in that same cycle. No
// clearing pass is needed after reset. The user must write thresholds over the APB port
// only while the block is idle; the block itself does not enforce this.
module sensor_report_dedup_table #(
   parameter int SLOTS = srd_pkg::SLOTS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  srd_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output srd_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [srd_pkg::CSR_AW-1:0]  paddr,
   input  logic [srd_pkg::CSR_DW-1:0]  pwdata,
   output logic [srd_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   srd_pkg::cfg_type   cfg;
   srd_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      scan_idx_ff, scan_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               cmp_bit_ff, cmp_bit_in;
   logic [IW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [IW-1:0]      match_idx_ff, match_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               publish_ff, publish_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   srd_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   srd_pkg::req_type   req_ff, req_in;
   srd_pkg::entry_type entry_ff, entry_in;

   logic               rd_en;
   srd_pkg::entry_type rd_data;
   logic               wr_en;
   srd_pkg::entry_type wr_data;

   logic [16:0] temp_diff, temp_abs;
   logic [7:0]  hum_diff, hum_abs;
   logic [8:0]  batt_diff, batt_abs;
   logic [31:0] elapsed;
   logic        changed;
   logic        is_report;

   srd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   srd_mem #(
      .DEPTH (SLOTS),
      .AW    (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != srd_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign is_report = (req_ff.cmd == srd_pkg::CMD_REPORT);

   // change detection against the matched entry
   assign temp_diff = {req_ff.temperature[15], req_ff.temperature}
                    - {entry_ff.temp[15], entry_ff.temp};
   assign temp_abs  = temp_diff[16] ? (~temp_diff + 17'd1) : temp_diff;
   assign hum_diff  = {1'b0, req_ff.humidity} - {1'b0, entry_ff.hum};
   assign hum_abs   = hum_diff[7] ? (~hum_diff + 8'd1) : hum_diff;
   assign batt_diff = {req_ff.battery[7], req_ff.battery} - {entry_ff.batt[7], entry_ff.batt};
   assign batt_abs  = batt_diff[8] ? (~batt_diff + 9'd1) : batt_diff;
   assign elapsed   = req_ff.now_ms - entry_ff.time_ms;
   assign changed   = (temp_abs > {3'd0, cfg.temp_thr})
                   || (hum_abs >= {1'b0, cfg.hum_thr})
                   || (!req_ff.battery[7] && (batt_abs >= {2'd0, cfg.batt_thr}));

   assign wr_en = (state_ff == srd_pkg::ST_FINISH) && is_report;

   always_comb begin
      if (publish_ff) begin
         wr_data.addr    = req_ff.device_addr;
         wr_data.kind    = req_ff.addr_kind;
         wr_data.time_ms = req_ff.now_ms;
         wr_data.temp    = req_ff.temperature;
         wr_data.hum     = req_ff.humidity;
         wr_data.batt    = req_ff.battery;
      end else begin
         wr_data      = entry_ff;
         wr_data.kind = req_ff.addr_kind;
      end
   end

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_bit_in    = cmp_bit_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      match_idx_in  = match_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      publish_in    = publish_ff;
      slot_in       = slot_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      req_in        = req_ff;
      entry_in      = entry_ff;
      rd_en         = 1'b0;

      // compare stage sees the entry read in the previous cycle
      if (cmp_vld_ff && cmp_bit_ff && !hit_ff && (rd_data.addr == req_ff.device_addr)) begin
         hit_in       = 1'b1;
         match_idx_in = cmp_idx_ff;
         entry_in     = rd_data;
      end

      case (state_ff)
         srd_pkg::ST_IDLE: begin
            if (start) begin
               req_in        = req_data;
               scan_idx_in   = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
               state_in      = srd_pkg::ST_SCAN;
            end
         end
         srd_pkg::ST_SCAN: begin
            rd_en      = 1'b1;
            cmp_vld_in = 1'b1;
            cmp_idx_in = scan_idx_ff;
            cmp_bit_in = valid_ff[scan_idx_ff];
            if (!free_found_ff && !valid_ff[scan_idx_ff]) begin
               free_found_in = 1'b1;
               free_idx_in   = scan_idx_ff;
            end
            if (scan_idx_ff == LAST_IDX) begin
               state_in = srd_pkg::ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         srd_pkg::ST_DRAIN: begin
            state_in = srd_pkg::ST_DECIDE;
         end
         srd_pkg::ST_DECIDE: begin
            if (!is_report) begin
               publish_in = 1'b0;
               slot_in    = hit_ff ? match_idx_ff : '0;
            end else if (hit_ff) begin
               publish_in = changed || (elapsed >= cfg.interval);
               slot_in    = match_idx_ff;
            end else begin
               // miss: lowest free slot, else evict slot 0
               publish_in = 1'b1;
               slot_in    = free_found_ff ? free_idx_ff : '0;
            end
            state_in = srd_pkg::ST_FINISH;
         end
         srd_pkg::ST_FINISH: begin
            if (is_report && publish_ff) begin
               valid_in[slot_ff] = 1'b1;
            end
            rsp_valid_in          = 1'b1;
            rsp_data_in.publish   = publish_ff;
            rsp_data_in.slot_used = srd_pkg::SLOT_OUT_W'(slot_ff);
            rsp_data_in.hit       = hit_ff;
            if (is_report) begin
               rsp_data_in.stored_kind = req_ff.addr_kind;
            end else begin
               rsp_data_in.stored_kind = hit_ff ? entry_ff.kind : 2'd0;
            end
            state_in = srd_pkg::ST_IDLE;
         end
         default: begin
            state_in = srd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= srd_pkg::ST_IDLE;
         scan_idx_ff   <= '0;
         cmp_vld_ff    <= 1'b0;
         cmp_bit_ff    <= 1'b0;
         cmp_idx_ff    <= '0;
         hit_ff        <= 1'b0;
         match_idx_ff  <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         publish_ff    <= 1'b0;
         slot_ff       <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_vld_ff    <= cmp_vld_in;
         cmp_bit_ff    <= cmp_bit_in;
         cmp_idx_ff    <= cmp_idx_in;
         hit_ff        <= hit_in;
         match_idx_ff  <= match_idx_in;
         free_found_ff <= free_found_in;
         free_idx_ff   <= free_idx_in;
         publish_ff    <= publish_in;
         slot_ff       <= slot_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      entry_ff    <= entry_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/srd_csr.sv]
module srd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [srd_pkg::CSR_AW-1:0]  paddr,
   input  logic [srd_pkg::CSR_DW-1:0]  pwdata,
   output logic [srd_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output srd_pkg::cfg_type            cfg
);

   srd_pkg::cfg_type cfg_ff;
   srd_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            srd_pkg::REG_TEMP_THR: cfg_in.temp_thr = pwdata[13:0];
            srd_pkg::REG_HUM_THR:  cfg_in.hum_thr  = pwdata[6:0];
            srd_pkg::REG_BATT_THR: cfg_in.batt_thr = pwdata[6:0];
            srd_pkg::REG_INTERVAL: cfg_in.interval = pwdata[31:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         srd_pkg::REG_TEMP_THR: prdata = {18'd0, cfg_ff.temp_thr};
         srd_pkg::REG_HUM_THR:  prdata = {25'd0, cfg_ff.hum_thr};
         srd_pkg::REG_BATT_THR: prdata = {25'd0, cfg_ff.batt_thr};
         srd_pkg::REG_INTERVAL: prdata = cfg_ff.interval;
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_thr <= srd_pkg::TEMP_THR_RESET;
         cfg_ff.hum_thr  <= srd_pkg::HUM_THR_RESET;
         cfg_ff.batt_thr <= srd_pkg::BATT_THR_RESET;
         cfg_ff.interval <= srd_pkg::INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/srd_mem.sv]
module srd_mem #(
   parameter int DEPTH = srd_pkg::SLOTS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  srd_pkg::entry_type wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output srd_pkg::entry_type rd_data
);

   srd_pkg::entry_type mem [DEPTH];
   srd_pkg::entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[tb/sensor_report_dedup_table_tb.sv]
module sensor_report_dedup_table_tb;

   localparam int SLOTS         = srd_pkg::SLOTS_DEFAULT;
   localparam int SETTLE_CYCLES = SLOTS + 12;
   localparam int STALL_LIMIT   = 1000;
   localparam int POOL_MAX      = 64;
   localparam int PHASE_ITEMS   = 235;

   logic                        clock   = 1'b0;
   logic                        reset   = 1'b1;
   logic                        start   = 1'b0;
   logic                        busy;
   srd_pkg::req_type            req_data = '0;
   logic                        rsp_valid;
   srd_pkg::rsp_type            rsp_data;
   logic                        psel    = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite  = 1'b0;
   logic [srd_pkg::CSR_AW-1:0]  paddr   = '0;
   logic [srd_pkg::CSR_DW-1:0]  pwdata  = '0;
   logic [srd_pkg::CSR_DW-1:0]  prdata;
   logic                        pready;

   // shadow copy of the sensor table and thresholds
   logic        slot_live  [SLOTS];
   logic [47:0] slot_addr  [SLOTS];
   logic [1:0]  slot_kind  [SLOTS];
   logic [31:0] slot_stamp [SLOTS];
   int          slot_temp  [SLOTS];
   int          slot_hum   [SLOTS];
   int          slot_batt  [SLOTS];
   logic [13:0] thr_temp     = srd_pkg::TEMP_THR_RESET;
   logic [6:0]  thr_hum      = srd_pkg::HUM_THR_RESET;
   logic [6:0]  thr_batt     = srd_pkg::BATT_THR_RESET;
   logic [31:0] republish_ms = srd_pkg::INTERVAL_RESET;

   srd_pkg::req_type report_queue [$];
   srd_pkg::rsp_type verdicts [$];
   srd_pkg::req_type cur_req = '0;
   int          sent_count = 0;
   int          taken_count = 0;
   bit          no_gaps = 1'b0;
   int          fail_count = 0;
   int          stall_cycles = 0;

   // sensors the stimulus keeps coming back to
   logic [47:0] dev_pool  [POOL_MAX];
   int          last_temp [POOL_MAX];
   int          last_hum  [POOL_MAX];
   int          last_batt [POOL_MAX];
   logic [31:0] clock_ms = '0;
   int          pool_used = POOL_MAX;

   sensor_report_dedup_table #(.SLOTS(SLOTS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int abs_gap(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic int clamp_pct(int v);
      return (v < 0) ? 0 : ((v > 100) ? 100 : v);
   endfunction

   // works out the verdict for one request and updates the shadow table
   function automatic srd_pkg::rsp_type dedup_decide(srd_pkg::req_type r);
      srd_pkg::rsp_type v;
      int          idx;
      int          i;
      int          t;
      int          h;
      int          b;
      bit          fresh;
      bit          changed;
      logic [31:0] elapsed;
      v = '0;
      idx = -1;
      t = int'($signed(r.temperature));
      h = int'(r.humidity);
      b = int'($signed(r.battery));
      for (i = 0; i < SLOTS; i++)
         if (idx < 0 && slot_live[i] && slot_addr[i] == r.device_addr)
            idx = i;
      if (r.cmd == srd_pkg::CMD_LOOKUP) begin
         if (idx >= 0) begin
            v.hit = 1'b1;
            v.slot_used = idx[srd_pkg::SLOT_OUT_W-1:0];
            v.stored_kind = slot_kind[idx];
         end
      end else begin
         fresh = (idx < 0);
         if (fresh) begin
            // lowest free slot, slot 0 when full
            idx = 0;
            for (i = SLOTS - 1; i >= 0; i--)
               if (!slot_live[i])
                  idx = i;
         end else begin
            v.hit = 1'b1;
         end
         v.slot_used = idx[srd_pkg::SLOT_OUT_W-1:0];
         slot_kind[idx] = r.addr_kind;
         v.stored_kind = r.addr_kind;
         changed = abs_gap(t, slot_temp[idx]) > int'(thr_temp) ||
                   abs_gap(h, slot_hum[idx]) >= int'(thr_hum) ||
                   (b >= 0 && abs_gap(b, slot_batt[idx]) >= int'(thr_batt));
         elapsed = r.now_ms - slot_stamp[idx];
         v.publish = fresh || changed || (elapsed >= republish_ms);
         if (v.publish) begin
            slot_live[idx]  = 1'b1;
            slot_addr[idx]  = r.device_addr;
            slot_stamp[idx] = r.now_ms;
            slot_temp[idx]  = t;
            slot_hum[idx]   = h;
            slot_batt[idx]  = b;
         end
      end
      return v;
   endfunction

   function automatic srd_pkg::req_type sensor_item(logic cmd, logic [47:0] a, logic [1:0] k,
                                                    int t, int h, int b, logic [31:0] n);
      srd_pkg::req_type r;
      r.cmd = cmd;
      r.device_addr = a;
      r.addr_kind = k;
      r.temperature = t[15:0];
      r.humidity = h[6:0];
      r.battery = b[7:0];
      r.now_ms = n;
      return r;
   endfunction

   // mostly readings that drift near the thresholds, some wild values
   function automatic srd_pkg::req_type next_sensor_report();
      srd_pkg::req_type r;
      logic [63:0] wide;
      int          p;
      int          span;
      int          step_max;
      r = '0;
      wide = {$urandom, $urandom};
      p = $urandom_range(0, pool_used - 1);
      r.cmd = ($urandom_range(0, 99) < 15) ? srd_pkg::CMD_LOOKUP : srd_pkg::CMD_REPORT;
      r.device_addr = ($urandom_range(0, 99) < 12) ? wide[47:0] : dev_pool[p];
      r.addr_kind = wide[49:48];

      if ($urandom_range(0, 99) < 80) begin
         span = int'(thr_temp) + 2;
         last_temp[p] = last_temp[p] + int'($urandom_range(0, 2 * span)) - span;
         r.temperature = last_temp[p][15:0];
      end else begin
         r.temperature = wide[63:48];
      end
      last_temp[p] = int'($signed(r.temperature));

      case ($urandom_range(0, 3))
         0: r.humidity = 7'($urandom_range(0, 127));
         1: r.humidity = 7'($urandom_range(0, 100));
         default: begin
            span = int'(thr_hum) + 1;
            r.humidity = 7'(clamp_pct(last_hum[p] + int'($urandom_range(0, 2 * span)) - span));
         end
      endcase
      last_hum[p] = int'(r.humidity);

      case ($urandom_range(0, 9))
         0, 1: r.battery = 8'hFF;
         2: r.battery = 8'($urandom_range(0, 255));
         3: r.battery = 8'($urandom_range(0, 100));
         default: begin
            span = int'(thr_batt) + 1;
            r.battery = 8'(clamp_pct(last_batt[p] + int'($urandom_range(0, 2 * span)) - span));
         end
      endcase
      if (!r.battery[7])
         last_batt[p] = int'(r.battery);

      step_max = (republish_ms > 32'd4_000_000) ? 60000 : int'(republish_ms >> 6) + 1;
      if ($urandom_range(0, 99) < 4)
         clock_ms = $urandom;
      else
         clock_ms = clock_ms + $urandom_range(0, step_max);
      r.now_ms = clock_ms;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (fail_count <= 100)
         $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         srd_pkg::REG_TEMP_THR: thr_temp = val[13:0];
         srd_pkg::REG_HUM_THR:  thr_hum = val[6:0];
         srd_pkg::REG_BATT_THR: thr_batt = val[6:0];
         srd_pkg::REG_INTERVAL: republish_ms = val;
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (report_queue.size() != 0 || sent_count != taken_count || verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [13:0] t, logic [6:0] h, logic [6:0] b,
                            logic [31:0] iv, int pool_n, bit quiet);
      csr_write(srd_pkg::REG_TEMP_THR, {18'd0, t});
      csr_write(srd_pkg::REG_HUM_THR, {25'd0, h});
      csr_write(srd_pkg::REG_BATT_THR, {25'd0, b});
      csr_write(srd_pkg::REG_INTERVAL, iv);
      pool_used = pool_n;
      no_gaps = quiet;
      repeat (PHASE_ITEMS) report_queue.push_back(next_sensor_report());
      wait_drained();
   endtask

   // request driver
   always @(negedge clock) begin
      if (sent_count == taken_count && report_queue.size() != 0) begin
         cur_req = report_queue.pop_front();
         sent_count++;
      end
      req_data <= cur_req;
      start <= (sent_count != taken_count) && (no_gaps || $urandom_range(0, 99) >= 9);
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         verdicts.push_back(dedup_decide(req_data));
         taken_count++;
      end
   end

   always @(posedge clock) begin : result_monitor
      srd_pkg::rsp_type want;
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (psel && penable && pwrite && pready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else if (rsp_valid) begin
            if (verdicts.size() == 0) begin
               report_mismatch("result with no request pending", '0, 32'(rsp_data));
            end else begin
               want = verdicts.pop_front();
               if (rsp_data.publish !== want.publish)
                  report_mismatch("publish", 32'(want.publish), 32'(rsp_data.publish));
               if (rsp_data.slot_used !== want.slot_used)
                  report_mismatch("slot_used", 32'(want.slot_used), 32'(rsp_data.slot_used));
               if (rsp_data.hit !== want.hit)
                  report_mismatch("hit", 32'(want.hit), 32'(rsp_data.hit));
               if (rsp_data.stored_kind !== want.stored_kind)
                  report_mismatch("stored_kind", 32'(want.stored_kind),
                                  32'(rsp_data.stored_kind));
            end
         end
      end
   end

   initial begin : stimulus
      logic [47:0] ones;
      logic [47:0] near;
      int          i;
      int          ph;
      ones = '1;
      near = 48'hFFFF_FFFF_FFFE;
      for (i = 0; i < SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_addr[i] = '0;
         slot_kind[i] = '0;
         slot_stamp[i] = '0;
         slot_temp[i] = 0;
         slot_hum[i] = 0;
         slot_batt[i] = 0;
      end
      for (i = 0; i < POOL_MAX; i += 2) begin
         dev_pool[i] = 48'({$urandom, $urandom});
         // neighbor differs in one address bit
         dev_pool[i + 1] = dev_pool[i] ^ (48'd1 << $urandom_range(0, 47));
      end
      for (i = 0; i < POOL_MAX; i++) begin
         last_temp[i] = int'($urandom_range(0, 4000)) - 1000;
         last_hum[i] = 50;
         last_batt[i] = 50;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed requests under reset thresholds
      report_queue.push_back(sensor_item(srd_pkg::CMD_LOOKUP, '0, 2'd0, 0, 0, 0, 0));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, '0, 2'd3, -32768, 0, -1, 0));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, ones, 2'd2, 32767, 127, 127,
                                         '1));
      report_queue.push_back(sensor_item(srd_pkg::CMD_LOOKUP, '0, 2'd0, 0, 0, 0, 0));
      report_queue.push_back(sensor_item(srd_pkg::CMD_LOOKUP, near, 2'd0, 0, 0, 0, 0));
      // hit with nothing moved: no publish, kind still updated
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, '0, 2'd1, -32768, 0, -1, 100));
      report_queue.push_back(sensor_item(srd_pkg::CMD_LOOKUP, '0, 2'd3, 0, 0, 0, 0));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, '0, 2'd1, -32758, 0, -1, 200));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, '0, 2'd1, -32757, 0, -1, 300));
      // time wraps past zero
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, ones, 2'd2, 32767, 126, 127,
                                         32'h1000));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, ones, 2'd2, 32767, 126, -128,
                                         32'h1010));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, ones, 2'd2, 32767, 126, 126,
                                         32'h1020));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, ones, 2'd2, 32767, 126, 126,
                                         32'h1020 + 32'd29999));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, ones, 2'd2, 32767, 126, 126,
                                         32'h1020 + 32'd30000));
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, near, 2'd0, 0, 50, 50, 5));
      report_queue.push_back(sensor_item(srd_pkg::CMD_LOOKUP, ones, 2'd0, 0, 0, 0, 0));
      // battery shows up after being absent
      report_queue.push_back(sensor_item(srd_pkg::CMD_REPORT, '0, 2'd1, -32757, 0, 0, 400));
      report_queue.push_back(sensor_item(srd_pkg::CMD_LOOKUP, 48'h8000_0000_0001, 2'd0,
                                         0, 0, 0, 0));
      report_queue.push_back(sensor_item(srd_pkg::CMD_LOOKUP, near, 2'd0, 0, 0, 0, 0));
      wait_drained();

      run_phase(14'd0, 7'd0, 7'd0, 32'd0, 40, 1'b0);
      run_phase(14'd10000, 7'd100, 7'd100, 32'hFFFF_FFFF, POOL_MAX, 1'b0);
      run_phase(srd_pkg::TEMP_THR_RESET, srd_pkg::HUM_THR_RESET, srd_pkg::BATT_THR_RESET,
                srd_pkg::INTERVAL_RESET, POOL_MAX, 1'b0);
      for (ph = 0; ph < 5; ph++)
         run_phase(14'($urandom_range(0, (ph == 2) ? 10000 : 300)),
                   7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)),
                   (ph == 2) ? $urandom : $urandom_range(50, 60000),
                   ph[0] ? 40 : POOL_MAX, ph == 1);

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
